/* hw/rtl/bt7ca_pkg.sv */
package bt7ca_pkg;

    // sample and accumulator widths
    typedef logic signed [15:0] sample_t;
    typedef logic signed [17:0] coef_t;
    typedef logic signed [39:0] wide_t;

    // pipeline depth, one register stage per entry
    localparam int unsigned NUM_STAGES = 10;

    // bt.709 coefficients in units of 2^-16
    localparam coef_t KY_R = 18'sd13933;
    localparam coef_t KY_G = 18'sd46871;
    localparam coef_t KY_B = 18'sd4732;
    localparam coef_t KU_R = -18'sd7504;
    localparam coef_t KU_G = -18'sd25264;
    localparam coef_t KU_B = 18'sd32768;
    localparam coef_t KV_R = 18'sd32768;
    localparam coef_t KV_G = -18'sd29773;
    localparam coef_t KV_B = -18'sd2995;
    localparam coef_t KR_V = 18'sd103206;
    localparam coef_t KG_U = -18'sd12242;
    localparam coef_t KG_V = -18'sd30671;
    localparam coef_t KB_U = 18'sd121635;

    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned COEF_BITS = 16;

    localparam logic signed [16:0] Q_ONE  = 17'sd4096;
    localparam logic signed [16:0] Q_HALF = 17'sd2048;

    typedef enum logic [1:0] {
        MODE_ALL   = 2'd0,
        MODE_RED   = 2'd1,
        MODE_GREEN = 2'd2,
        MODE_BLUE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_MODE   = 3'd0,
        REG_RED_GAIN       = 3'd1,
        REG_GREEN_GAIN     = 3'd2,
        REG_BLUE_GAIN      = 3'd3,
        REG_LUMA_GAIN      = 3'd4,
        REG_CONTRAST_RATIO = 3'd5,
        REG_GRAY_ENABLE    = 3'd6,
        REG_INVERT_ENABLE  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t   channel_mode;
        sample_t red_gain;
        sample_t green_gain;
        sample_t blue_gain;
        sample_t luma_gain;
        sample_t contrast_ratio;
        logic    gray_enable;
        logic    invert_enable;
    } cfg_t;

    typedef struct packed {
        sample_t red_in;
        sample_t green_in;
        sample_t blue_in;
    } in_word_t;

    typedef struct packed {
        sample_t red_out;
        sample_t green_out;
        sample_t blue_out;
        logic    clipped;
    } out_word_t;

    typedef struct packed {
        sample_t val;
        logic    clip;
    } sat_t;

    // clamp to 16-bit signed range
    function automatic sat_t sat16(input wide_t v);
        sat_t res;
        if (v > wide_t'(32767))
        begin
            res.val  = 16'sh7FFF;
            res.clip = 1'b1;
        end
        else if (v < wide_t'(-32768))
        begin
            res.val  = -16'sh8000;
            res.clip = 1'b1;
        end
        else
        begin
            res.val  = v[15:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

    // round to nearest, ties upward, then clamp
    function automatic sat_t rnd_sat(input wide_t v, input int unsigned s);
        wide_t bias;
        wide_t r;
        bias = wide_t'(1) <<< (s - 1);
        r    = (v + bias) >>> s;
        return sat16(r);
    endfunction

    // sample times coefficient, widened to accumulator
    function automatic wide_t mulk(input sample_t a, input coef_t k);
        logic signed [33:0] p;
        p = a * k;
        return wide_t'(p);
    endfunction

endpackage

/* hw/rtl/bt7ca_stream_if.sv */
interface bt7ca_stream_if #(
    parameter type word_t = logic
) ();

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* hw/rtl/bt7ca_cfg_regs.sv */
module bt7ca_cfg_regs
    import bt7ca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CHANNEL_MODE:   cfg_next.channel_mode   = mode_t'(cfg_data[1:0]);
                REG_RED_GAIN:       cfg_next.red_gain       = cfg_data;
                REG_GREEN_GAIN:     cfg_next.green_gain     = cfg_data;
                REG_BLUE_GAIN:      cfg_next.blue_gain      = cfg_data;
                REG_LUMA_GAIN:      cfg_next.luma_gain      = cfg_data;
                REG_CONTRAST_RATIO: cfg_next.contrast_ratio = cfg_data;
                REG_GRAY_ENABLE:    cfg_next.gray_enable    = cfg_data[0];
                REG_INVERT_ENABLE:  cfg_next.invert_enable  = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_mode   <= MODE_ALL;
            cfg_reg.red_gain       <= 16'sd4096;
            cfg_reg.green_gain     <= 16'sd4096;
            cfg_reg.blue_gain      <= 16'sd4096;
            cfg_reg.luma_gain      <= 16'sd4096;
            cfg_reg.contrast_ratio <= 16'sd4096;
            cfg_reg.gray_enable    <= 1'b0;
            cfg_reg.invert_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/bt709_yuv_color_adjust.sv */
// bt.709 colour adjust: one signed q4.12 rgb pixel per word in, one adjusted
// pixel per word out. a new word is accepted every clock cycle while the output is
// ready or a stage is empty; there are ten pipeline stages (gain multiply, gain
// round and channel select, yuv sums, yuv round and luma-gain multiply, luma
// round, rgb sums, rgb round and contrast multiply, contrast round, grey sum,
// grey and invert), which a word passes in that order to the output register,
// leaving it once ready is high. a stall at the output backs up only as far as
// the first empty stage, so bubbles keep filling while a finished word waits.
// configuration writes take effect at once and must only be made while no
// words are in flight.
module bt709_yuv_color_adjust
    import bt7ca_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    bt7ca_stream_if.sink    pixels,
    bt7ca_stream_if.source  adjusted
);

    localparam int unsigned LAST = NUM_STAGES - 1;

    cfg_t cfg;

    bt7ca_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || adjusted.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = pixels.valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixels.ready   = stage_en[0];
    assign adjusted.valid = valid_reg[LAST];

    // ------------------------------------------------------------------
    // stage 0: per-channel gain products
    // ------------------------------------------------------------------
    logic signed [31:0] s0_prod_reg [3];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_prod_reg[0] <= pixels.data.red_in   * cfg.red_gain;
            s0_prod_reg[1] <= pixels.data.green_in * cfg.green_gain;
            s0_prod_reg[2] <= pixels.data.blue_in  * cfg.blue_gain;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: round gains, drop channels not kept
    // ------------------------------------------------------------------
    sat_t    s1_k [3];
    sample_t s1_c_reg [3];
    logic    s1_clip_reg;
    logic [2:0] s1_keep;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_k[i] = rnd_sat(wide_t'(s0_prod_reg[i]), FRAC_BITS);
        end
        case (cfg.channel_mode)
            MODE_ALL:   s1_keep = 3'b111;
            MODE_RED:   s1_keep = 3'b001;
            MODE_GREEN: s1_keep = 3'b010;
            MODE_BLUE:  s1_keep = 3'b100;
            default:    s1_keep = 3'b111;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_c_reg[i] <= s1_keep[i] ? s1_k[i].val : '0;
            end
            // clamping counts even on a dropped channel
            s1_clip_reg <= s1_k[0].clip | s1_k[1].clip | s1_k[2].clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: y, u, v constant-coefficient sums
    // ------------------------------------------------------------------
    wide_t s2_y_reg, s2_u_reg, s2_v_reg;
    logic  s2_clip_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s2_y_reg <= mulk(s1_c_reg[0], KY_R) + mulk(s1_c_reg[1], KY_G)
                      + mulk(s1_c_reg[2], KY_B);
            s2_u_reg <= mulk(s1_c_reg[0], KU_R) + mulk(s1_c_reg[1], KU_G)
                      + mulk(s1_c_reg[2], KU_B);
            s2_v_reg <= mulk(s1_c_reg[0], KV_R) + mulk(s1_c_reg[1], KV_G)
                      + mulk(s1_c_reg[2], KV_B);
            s2_clip_reg <= s1_clip_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round y, u, v; luma gain product
    // ------------------------------------------------------------------
    sat_t s3_y, s3_u, s3_v;
    logic signed [31:0] s3_yprod_reg;
    sample_t s3_u_reg, s3_v_reg;
    logic    s3_clip_reg;

    always_comb
    begin
        s3_y = rnd_sat(s2_y_reg, COEF_BITS);
        s3_u = rnd_sat(s2_u_reg, COEF_BITS);
        s3_v = rnd_sat(s2_v_reg, COEF_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s3_yprod_reg <= s3_y.val * cfg.luma_gain;
            s3_u_reg     <= s3_u.val;
            s3_v_reg     <= s3_v.val;
            s3_clip_reg  <= s2_clip_reg | s3_y.clip | s3_u.clip | s3_v.clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round scaled luma
    // ------------------------------------------------------------------
    sat_t    s4_y;
    sample_t s4_y_reg, s4_u_reg, s4_v_reg;
    logic    s4_clip_reg;

    assign s4_y = rnd_sat(wide_t'(s3_yprod_reg), FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s4_y_reg    <= s4_y.val;
            s4_u_reg    <= s3_u_reg;
            s4_v_reg    <= s3_v_reg;
            s4_clip_reg <= s3_clip_reg | s4_y.clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: back to rgb sums
    // ------------------------------------------------------------------
    wide_t s5_ysh;
    wide_t s5_sum_reg [3];
    logic  s5_clip_reg;

    assign s5_ysh = wide_t'(s4_y_reg) <<< COEF_BITS;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s5_sum_reg[0] <= s5_ysh + mulk(s4_v_reg, KR_V);
            s5_sum_reg[1] <= s5_ysh + mulk(s4_u_reg, KG_U) + mulk(s4_v_reg, KG_V);
            s5_sum_reg[2] <= s5_ysh + mulk(s4_u_reg, KB_U);
            s5_clip_reg   <= s4_clip_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: round rgb; contrast product around mid grey
    // ------------------------------------------------------------------
    sat_t               s6_c [3];
    logic signed [16:0] s6_d [3];
    logic signed [32:0] s6_prod_reg [3];
    sample_t            s6_c_reg [3];
    logic               s6_clip_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_c[i] = rnd_sat(s5_sum_reg[i], COEF_BITS);
            s6_d[i] = 17'(s6_c[i].val) - Q_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_prod_reg[i] <= s6_d[i] * cfg.contrast_ratio;
                s6_c_reg[i]    <= s6_c[i].val;
            end
            s6_clip_reg <= s5_clip_reg | s6_c[0].clip | s6_c[1].clip | s6_c[2].clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: contrast add and round
    // ------------------------------------------------------------------
    sat_t    s7_c [3];
    sample_t s7_c_reg [3];
    logic    s7_clip_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s7_c[i] = rnd_sat((wide_t'(s6_c_reg[i]) <<< FRAC_BITS)
                              + wide_t'(s6_prod_reg[i]), FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_c_reg[i] <= s7_c[i].val;
            end
            s7_clip_reg <= s6_clip_reg | s7_c[0].clip | s7_c[1].clip | s7_c[2].clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: grey luma sum
    // ------------------------------------------------------------------
    wide_t   s8_gsum_reg;
    sample_t s8_c_reg [3];
    logic    s8_clip_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            s8_gsum_reg <= mulk(s7_c_reg[0], KY_R) + mulk(s7_c_reg[1], KY_G)
                         + mulk(s7_c_reg[2], KY_B);
            for (int i = 0; i < 3; i++)
            begin
                s8_c_reg[i] <= s7_c_reg[i];
            end
            s8_clip_reg <= s7_clip_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: grey select, invert, output register
    // ------------------------------------------------------------------
    sat_t               s9_g;
    sample_t            s9_sel [3];
    sat_t               s9_inv [3];
    sample_t            s9_fin [3];
    logic               s9_clip;
    out_word_t          s9_out_reg;

    always_comb
    begin
        s9_g    = rnd_sat(s8_gsum_reg, COEF_BITS);
        s9_clip = s8_clip_reg | (cfg.gray_enable & s9_g.clip);
        for (int i = 0; i < 3; i++)
        begin
            s9_sel[i] = cfg.gray_enable ? s9_g.val : s8_c_reg[i];
            s9_inv[i] = sat16(wide_t'(Q_ONE - 17'(s9_sel[i])));
            s9_fin[i] = cfg.invert_enable ? s9_inv[i].val : s9_sel[i];
            s9_clip   = s9_clip | (cfg.invert_enable & s9_inv[i].clip);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[9])
        begin
            s9_out_reg.red_out   <= s9_fin[0];
            s9_out_reg.green_out <= s9_fin[1];
            s9_out_reg.blue_out  <= s9_fin[2];
            s9_out_reg.clipped   <= s9_clip;
        end
    end

    assign adjusted.data = s9_out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // input back-pressure only when every stage holds a word
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // an accepted word always lands in the first stage
    a_accept_loads_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.ready) |=> valid_reg[0])
        else $error("accepted word lost at pipeline entry");

    // grey mode gives three equal channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (adjusted.valid && cfg.gray_enable) |->
            (adjusted.data.red_out == adjusted.data.green_out
             && adjusted.data.green_out == adjusted.data.blue_out))
        else $error("grey output channels differ");

endmodule

/* sim/bt7ca_pixel_checker.sv */
`timescale 1ns / 100ps

module bt7ca_pixel_checker
    import bt7ca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_word_t   out_word,
    output int          pending,
    output int          mismatches
);

    // bt.709 coefficients, units of 2^-16
    localparam longint LUMA_R = 13933;
    localparam longint LUMA_G = 46871;
    localparam longint LUMA_B = 4732;
    localparam longint CB_R = -7504;
    localparam longint CB_G = -25264;
    localparam longint CB_B = 32768;
    localparam longint CR_R = 32768;
    localparam longint CR_G = -29773;
    localparam longint CR_B = -2995;
    localparam longint RED_FROM_V = 103206;
    localparam longint GREEN_FROM_U = -12242;
    localparam longint GREEN_FROM_V = -30671;
    localparam longint BLUE_FROM_U = 121635;
    localparam longint UNITY = 4096;
    localparam longint MID_GREY = 2048;

    // shadow of the block's registers
    mode_t   mode_sel;
    sample_t gain_red;
    sample_t gain_green;
    sample_t gain_blue;
    sample_t gain_luma;
    sample_t contrast;
    logic    grey_on;
    logic    invert_on;

    out_word_t expected_pixels[$];
    int        words_checked = 0;
    int        fail_count = 0;

    assign mismatches = fail_count;

    // round to nearest (ties up) at shift s, then clamp to 16-bit signed
    function automatic longint round_clamp(input longint v, input int s, inout bit clip);
        longint r;
        if (s == 0)
            r = v;
        else
            r = (v + (longint'(1) <<< (s - 1))) >>> s;
        if (r > 32767)
        begin
            clip = 1'b1;
            r = 32767;
        end
        else if (r < -32768)
        begin
            clip = 1'b1;
            r = -32768;
        end
        return r;
    endfunction

    function automatic out_word_t adjust_pixel(input in_word_t px);
        longint    c [0:2];
        longint    y;
        longint    u;
        longint    v;
        longint    g;
        bit        clip;
        int        i;
        out_word_t res;
        clip = 1'b0;
        c[0] = round_clamp(longint'(px.red_in) * longint'(gain_red), 12, clip);
        c[1] = round_clamp(longint'(px.green_in) * longint'(gain_green), 12, clip);
        c[2] = round_clamp(longint'(px.blue_in) * longint'(gain_blue), 12, clip);
        case (mode_sel)
            MODE_RED:
            begin
                c[1] = 0;
                c[2] = 0;
            end
            MODE_GREEN:
            begin
                c[0] = 0;
                c[2] = 0;
            end
            MODE_BLUE:
            begin
                c[0] = 0;
                c[1] = 0;
            end
            default: ;
        endcase

        y = round_clamp(LUMA_R * c[0] + LUMA_G * c[1] + LUMA_B * c[2], 16, clip);
        y = round_clamp(longint'(gain_luma) * y, 12, clip);
        u = round_clamp(CB_R * c[0] + CB_G * c[1] + CB_B * c[2], 16, clip);
        v = round_clamp(CR_R * c[0] + CR_G * c[1] + CR_B * c[2], 16, clip);

        c[0] = round_clamp(y * 65536 + RED_FROM_V * v, 16, clip);
        c[1] = round_clamp(y * 65536 + GREEN_FROM_U * u + GREEN_FROM_V * v, 16, clip);
        c[2] = round_clamp(y * 65536 + BLUE_FROM_U * u, 16, clip);

        for (i = 0; i < 3; i++)
            c[i] = round_clamp(c[i] * UNITY + (c[i] - MID_GREY) * longint'(contrast), 12, clip);

        if (grey_on)
        begin
            g = round_clamp(LUMA_R * c[0] + LUMA_G * c[1] + LUMA_B * c[2], 16, clip);
            c[0] = g;
            c[1] = g;
            c[2] = g;
        end

        if (invert_on)
            for (i = 0; i < 3; i++)
                c[i] = round_clamp(UNITY - c[i], 0, clip);

        res.red_out   = sample_t'(c[0]);
        res.green_out = sample_t'(c[1]);
        res.blue_out  = sample_t'(c[2]);
        res.clipped   = clip;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: word %0d, %s: got %0d, expected %0d",
                 $realtime, words_checked, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            mode_sel   <= MODE_ALL;
            gain_red   <= 16'sd4096;
            gain_green <= 16'sd4096;
            gain_blue  <= 16'sd4096;
            gain_luma  <= 16'sd4096;
            contrast   <= 16'sd4096;
            grey_on    <= 1'b0;
            invert_on  <= 1'b0;
            expected_pixels.delete();
            pending    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CHANNEL_MODE:   mode_sel   <= mode_t'(cfg_data[1:0]);
                    REG_RED_GAIN:       gain_red   <= cfg_data;
                    REG_GREEN_GAIN:     gain_green <= cfg_data;
                    REG_BLUE_GAIN:      gain_blue  <= cfg_data;
                    REG_LUMA_GAIN:      gain_luma  <= cfg_data;
                    REG_CONTRAST_RATIO: contrast   <= cfg_data;
                    REG_GRAY_ENABLE:    grey_on    <= cfg_data[0];
                    REG_INVERT_ENABLE:  invert_on  <= cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected word, red_out", out_word.red_out, 0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_word.red_out !== want.red_out)
                        report_mismatch("red_out", out_word.red_out, want.red_out);
                    if (out_word.green_out !== want.green_out)
                        report_mismatch("green_out", out_word.green_out, want.green_out);
                    if (out_word.blue_out !== want.blue_out)
                        report_mismatch("blue_out", out_word.blue_out, want.blue_out);
                    if (out_word.clipped !== want.clipped)
                        report_mismatch("clipped", out_word.clipped, want.clipped);
                end
                words_checked++;
            end

            if (in_valid && in_ready)
                expected_pixels.push_back(adjust_pixel(in_word));

            pending <= expected_pixels.size();
        end
    end

endmodule

/* sim/bt709_yuv_color_adjust_tb.sv */
`timescale 1ns / 100ps

// stimulus and verdict for the bt.709 colour adjust pipeline
// the checker beside the block watches both channels and the register port,
// predicts every output word and counts mismatches; this module only drives
module bt709_yuv_color_adjust_tb
    import bt7ca_pkg::*;
();

    // far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // long output hold-off, well beyond the ten pipeline stages
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_PHASES = 13;
    localparam int WORDS_PER_PHASE = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // idling controls shared between the stimulus and the output side
    logic        tx_idle_on;
    logic        rx_idle_on;
    // toggled by the stimulus, each change asks for one long hold-off
    logic        hold_request;

    int          pending;
    int          mismatches;
    int          cycle_count = 0;

    bt7ca_stream_if #(.word_t(in_word_t))  pixels ();
    bt7ca_stream_if #(.word_t(out_word_t)) adjusted ();

    bt709_yuv_color_adjust uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .adjusted  (adjusted)
    );

    bt7ca_pixel_checker pixel_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (pixels.valid),
        .in_ready   (pixels.ready),
        .in_word    (pixels.data),
        .out_valid  (adjusted.valid),
        .out_ready  (adjusted.ready),
        .out_word   (adjusted.data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // small constructors and random draws
    // ---------------------------------------------------------------

    function automatic in_word_t mk_pixel(input sample_t r, input sample_t g, input sample_t b);
        in_word_t w;
        w.red_in   = r;
        w.green_in = g;
        w.blue_in  = b;
        return w;
    endfunction

    function automatic cfg_t settings(input mode_t mode, input sample_t rg, input sample_t gg,
                                      input sample_t bg, input sample_t lg, input sample_t cr,
                                      input logic grey, input logic inv);
        cfg_t s;
        s.channel_mode   = mode;
        s.red_gain       = rg;
        s.green_gain     = gg;
        s.blue_gain      = bg;
        s.luma_gain      = lg;
        s.contrast_ratio = cr;
        s.gray_enable    = grey;
        s.invert_enable  = inv;
        return s;
    endfunction

    function automatic sample_t pick_extreme();
        sample_t r;
        case ($urandom_range(0, 3))
            0:       r = 16'sh7FFF;
            1:       r = sample_t'(16'h8000);
            2:       r = 16'sh0000;
            default: r = sample_t'(16'hFFFF);
        endcase
        return r;
    endfunction

    // mostly the nominal 0..1 range, some wider or out-of-range values, a few corners
    function automatic sample_t rand_sample();
        sample_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r = sample_t'($urandom_range(0, 4096));
            5, 6:          r = sample_t'($urandom);
            7, 8:          r = sample_t'($urandom_range(0, 12288) - 4096);
            default:       r = pick_extreme();
        endcase
        return r;
    endfunction

    function automatic sample_t rand_gain();
        sample_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r = sample_t'($urandom_range(2048, 6144));
            5, 6:          r = sample_t'($urandom);
            7:             r = sample_t'(-$urandom_range(0, 8192));
            default:       r = pick_extreme();
        endcase
        return r;
    endfunction

    // contrast ratio is usually small, now and then anything at all
    function automatic sample_t rand_ratio();
        sample_t r;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: r = sample_t'($urandom_range(0, 4096) - 2048);
            4:          r = 16'sd0;
            5:          r = sample_t'($urandom);
            default:    r = pick_extreme();
        endcase
        return r;
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t s;
        s.channel_mode   = mode_t'($urandom_range(0, 3));
        s.red_gain       = rand_gain();
        s.green_gain     = rand_gain();
        s.blue_gain      = rand_gain();
        s.luma_gain      = rand_gain();
        s.contrast_ratio = rand_ratio();
        s.gray_enable    = ($urandom_range(0, 3) == 0);
        s.invert_enable  = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    function automatic in_word_t rand_pixel();
        return mk_pixel(rand_sample(), rand_sample(), rand_sample());
    endfunction

    // ---------------------------------------------------------------
    // drivers; every task is entered and left just after a rising edge
    // ---------------------------------------------------------------

    // offer one word, optionally after a short idle burst, and wait for acceptance
    task automatic send_pixel(input in_word_t w);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            pixels.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.data  <= w;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
    endtask

    // stop offering and let every word in flight come out
    task automatic drain();
        pixels.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // full register load once the pipe is empty; the narrow registers get
    // random junk above their width, which the block has to ignore
    task automatic apply_settings(input cfg_t s);
        logic [15:0] junk;
        drain();
        junk = $urandom;
        write_reg(REG_CHANNEL_MODE, {junk[15:2], s.channel_mode});
        write_reg(REG_RED_GAIN, s.red_gain);
        write_reg(REG_GREEN_GAIN, s.green_gain);
        write_reg(REG_BLUE_GAIN, s.blue_gain);
        write_reg(REG_LUMA_GAIN, s.luma_gain);
        write_reg(REG_CONTRAST_RATIO, s.contrast_ratio);
        junk = $urandom;
        write_reg(REG_GRAY_ENABLE, {junk[15:1], s.gray_enable});
        junk = $urandom;
        write_reg(REG_INVERT_ENABLE, {junk[15:1], s.invert_enable});
        cfg_write <= 1'b0;
    endtask

    // colour corners that stress saturation points in the chain
    task automatic send_corner_pixels();
        send_pixel(mk_pixel(16'sh7FFF, sample_t'(16'h8000), 16'sd1));
        send_pixel(mk_pixel(sample_t'(16'h8000), 16'sh7FFF, 16'sd4096));
        send_pixel(mk_pixel(16'sd2047, sample_t'(16'hFFFF), -16'sd4097));
    endtask

    // ---------------------------------------------------------------
    // output side: random stalls, plus one long hold-off when asked
    // ---------------------------------------------------------------
    initial
    begin
        int   stall;
        logic hold_seen;
        hold_seen = 1'b0;
        adjusted.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request != hold_seen)
            begin
                // block fills up behind this and has to stall its input
                hold_seen      = hold_request;
                adjusted.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                adjusted.ready <= 1'b0;
                stall = $urandom_range(1, 4);
                repeat (stall) @(posedge clk);
            end
            else
            begin
                adjusted.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int p;
        int n;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_CHANNEL_MODE;
        cfg_data     = '0;
        pixels.valid = 1'b0;
        pixels.data  = '0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unity gains, unity contrast ratio, no grey, no invert
        send_pixel(mk_pixel(16'sd0, 16'sd0, 16'sd0));
        send_pixel(mk_pixel(16'sd4096, 16'sd4096, 16'sd4096));
        send_pixel(mk_pixel(16'sd2048, 16'sd2048, 16'sd2048));
        send_pixel(mk_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_pixel(mk_pixel(sample_t'(16'h8000), sample_t'(16'h8000), sample_t'(16'h8000)));
        send_pixel(mk_pixel(16'sh7FFF, sample_t'(16'h8000), sample_t'(16'hFFFF)));

        // red only, largest positive and negative gains, contrast ratio zero
        apply_settings(settings(MODE_RED, 16'sh7FFF, sample_t'(16'h8000), 16'sd4096,
                                16'sd4096, 16'sd0, 1'b0, 1'b0));
        send_corner_pixels();

        // green only, everything at the negative limit, grey and invert both on
        apply_settings(settings(MODE_GREEN, sample_t'(16'h8000), sample_t'(16'h8000),
                                sample_t'(16'h8000), sample_t'(16'h8000),
                                sample_t'(16'h8000), 1'b1, 1'b1));
        send_corner_pixels();

        // blue only, positive limits on luma and contrast, invert alone
        apply_settings(settings(MODE_BLUE, 16'sd4096, 16'sd4096, 16'sh7FFF, 16'sh7FFF,
                                16'sh7FFF, 1'b0, 1'b1));
        send_corner_pixels();

        // all channels with zero gains and zero luma gain, grey alone
        apply_settings(settings(MODE_ALL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096,
                                1'b1, 1'b0));
        send_corner_pixels();

        // random settings per phase; idling varies by phase and is off at the end
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_settings(rand_settings());
            tx_idle_on <= (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on <= (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if ((p == 2 || p == 8) && n == 20)
                    hold_request <= ~hold_request;
                send_pixel(rand_pixel());
            end
        end

        drain();
        // keep the clock running so that a stray extra word would still be caught
        repeat (NUM_STAGES + 8) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
